// ----- hw/rtl/tga_rle_pkg.sv -----
// shared types and constants of the tga run-length pixel decoder
package tga_rle_pkg;

  typedef enum logic [1:0] {
    FMT_8  = 2'd0,
    FMT_16 = 2'd1,
    FMT_24 = 2'd2,
    FMT_32 = 2'd3
  } fmt_t;

  typedef enum logic {
    FUNC_PALETTE = 1'b0,
    FUNC_PIXEL   = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    CFG_PIXEL_FORMAT   = 2'd0,
    CFG_RLE_ENABLED    = 2'd1,
    CFG_PALETTE_LENGTH = 2'd2
  } cfg_idx_t;

  localparam logic [7:0] LOW_SEVEN   = 8'h7F;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // one completed pixel on its way to colour conversion
  typedef struct packed {
    fmt_t        fmt;
    logic        pal_mode;
    logic        miss;
    logic [23:0] bytes;
    logic [7:0]  last;
    logic [7:0]  count;
  } pix_t;

endpackage

// ----- hw/rtl/tga_rle_pixel_decoder_unit.sv -----
// top level of the tga run-length pixel decoder
//
// input stream s_*: one item per tga pixel-data byte or palette write,
// s_tuser selects which. palette writes never give a result and are to be loaded before
// the image (the block does not enforce this); header bytes and partial pixels give none.
// each completed pixel leaves on m_* as an rgba colour with a repeat count.
//
// pipeline: the parse stage gathers bytes and tracks packets, then a
// register stage holds the pixel while the palette memory's registered
// read completes, then the colour is converted into the output register.
// throughput is one item per cycle: s_tready stays high whenever the
// first stage is empty or moves on, which it does whenever the output
// register is empty or being taken.
//
// when the receiver stalls, the output register holds, the first stage holds once it
// has a result, and at most two results wait; s_tready then drops until m_tready returns.
// rst (synchronous) clears the packet state, empties the pipeline and
// sets pixel_format to 24-bit, rle off, palette_length 0. palette contents
// are not cleared and must be written before use.
module tga_rle_pixel_decoder_unit import tga_rle_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // palette_index[7:0], palette_color[31:8], data_byte[39:32]
  input  logic        s_tuser,   // func: 0 palette write, 1 pixel data byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // red, green, blue, alpha, repeat_count from bit 0 up
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int IdxW = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] DepthW = 9'(PALETTE_DEPTH);

  // configuration registers
  fmt_t       pixel_format;
  logic       rle_enabled;
  logic [8:0] palette_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format   <= FMT_24;
      rle_enabled    <= 1'b0;
      palette_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PIXEL_FORMAT:   pixel_format   <= fmt_t'(cfg_data[1:0]);
        CFG_RLE_ENABLED:    rle_enabled    <= cfg_data[0];
        CFG_PALETTE_LENGTH: palette_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // input fields
  func_t       func;
  logic [7:0]  palette_index;
  logic [23:0] palette_color;
  logic [7:0]  data_byte;

  assign func          = func_t'(s_tuser);
  assign palette_index = s_tdata[7:0];
  assign palette_color = s_tdata[31:8];
  assign data_byte     = s_tdata[39:32];

  // flow control: output register frees, then the first stage can load
  logic advance;
  logic load;
  logic accept;
  logic s1_valid;

  assign advance  = !m_tvalid || m_tready;
  assign load     = !s1_valid || advance;
  assign s_tready = load;
  assign accept   = s_tvalid && load;

  // palette writes beyond the store are dropped
  logic            pal_we;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [23:0]     pal_data;
  pix_t            s1;

  assign pal_we = accept && (func == FUNC_PALETTE) && ({1'b0, palette_index} < DepthW);

  tga_rle_parse #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_parse (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .accept         (accept),
    .func           (func),
    .data_byte      (data_byte),
    .fmt            (pixel_format),
    .rle_enabled    (rle_enabled),
    .palette_length (palette_length),
    .s1_valid       (s1_valid),
    .s1             (s1),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr)
  );

  tga_rle_palette #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_palette (
    .clk     (clk),
    .we      (pal_we),
    .wr_addr (palette_index[IdxW-1:0]),
    .wr_data (palette_color),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (pal_data)
  );

  tga_rle_color u_color (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .pal_data  (pal_data),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule

// ----- hw/rtl/tga_rle_palette.sv -----
// palette memory, one write port and one registered read port
module tga_rle_palette import tga_rle_pkg::*; #(
  parameter int PALETTE_DEPTH = 256,
  localparam int IdxW = $clog2(PALETTE_DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [IdxW-1:0] wr_addr,
  input  logic [23:0]     wr_data,
  input  logic            rd_en,
  input  logic [IdxW-1:0] rd_addr,
  output logic [23:0]     rd_data
);

  logic [23:0] mem [PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/tga_rle_parse.sv -----
// packet header handling, byte gathering and the first pipeline register
module tga_rle_parse import tga_rle_pkg::*; #(
  parameter int PALETTE_DEPTH = 256,
  localparam int IdxW = $clog2(PALETTE_DEPTH)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic            accept,
  input  func_t           func,
  input  logic [7:0]      data_byte,
  input  fmt_t            fmt,
  input  logic            rle_enabled,
  input  logic [8:0]      palette_length,
  output logic            s1_valid,
  output pix_t            s1,
  output logic            rd_en,
  output logic [IdxW-1:0] rd_addr
);

  localparam logic [8:0] DepthW = 9'(PALETTE_DEPTH);

  logic [7:0]  pixels_left, pixels_left_next;
  logic        packet_is_run, packet_is_run_next;
  logic [23:0] pixel_bytes, pixel_bytes_next;
  logic [1:0]  byte_position, byte_position_next;

  logic        header;
  logic        complete;
  logic        pixel_item;
  logic [23:0] merged;
  logic        miss;
  pix_t        pix;

  always_comb begin
    header     = rle_enabled && (pixels_left == 8'd0);
    complete   = !header && (byte_position >= fmt);
    pixel_item = accept && (func == FUNC_PIXEL);

    // current byte dropped into its slot; a fourth byte only feeds alpha
    unique case (byte_position)
      2'd0:    merged = pixel_bytes | {16'd0, data_byte};
      2'd1:    merged = pixel_bytes | {8'd0, data_byte, 8'd0};
      2'd2:    merged = pixel_bytes | {data_byte, 16'd0};
      default: merged = pixel_bytes;
    endcase

    miss    = ({1'b0, merged[7:0]} >= palette_length) || ({1'b0, merged[7:0]} >= DepthW);
    rd_addr = merged[IdxW-1:0];
    rd_en   = pixel_item && complete;

    pix.fmt      = fmt;
    pix.pal_mode = (palette_length != 9'd0);
    pix.miss     = miss;
    pix.bytes    = merged;
    pix.last     = data_byte;
    pix.count    = (rle_enabled && packet_is_run) ? pixels_left : 8'd1;

    pixels_left_next   = pixels_left;
    packet_is_run_next = packet_is_run;
    pixel_bytes_next   = pixel_bytes;
    byte_position_next = byte_position;
    if (pixel_item) begin
      priority if (header) begin
        packet_is_run_next = data_byte[7];
        pixels_left_next   = (data_byte & LOW_SEVEN) + 8'd1;
        pixel_bytes_next   = '0;
        byte_position_next = '0;
      end else if (!complete) begin
        pixel_bytes_next   = merged;
        byte_position_next = byte_position + 2'd1;
      end else begin
        pixel_bytes_next   = '0;
        byte_position_next = '0;
        if (rle_enabled) begin
          pixels_left_next = packet_is_run ? 8'd0 : pixels_left - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_left   <= '0;
      packet_is_run <= 1'b0;
      pixel_bytes   <= '0;
      byte_position <= '0;
      s1_valid      <= 1'b0;
    end else begin
      pixels_left   <= pixels_left_next;
      packet_is_run <= packet_is_run_next;
      pixel_bytes   <= pixel_bytes_next;
      byte_position <= byte_position_next;
      if (load) begin
        s1_valid <= pixel_item && complete;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1 <= pix;
    end
  end

endmodule

// ----- hw/rtl/tga_rle_color.sv -----
// colour conversion of a completed pixel and the output register
module tga_rle_color import tga_rle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        s1_valid,
  input  pix_t        s1,
  input  logic [23:0] pal_data,
  output logic        out_valid,
  output logic [39:0] out_data
);

  logic [7:0]  red, green, blue, alpha;
  logic [7:0]  b0, b1, b2;
  logic [15:0] p;

  always_comb begin
    b0 = s1.bytes[7:0];
    b1 = s1.bytes[15:8];
    b2 = s1.bytes[23:16];
    p  = {b1, b0};
    alpha = ALPHA_OPAQUE;
    unique case (s1.fmt)
      FMT_8: begin
        if (!s1.pal_mode) begin
          red = b0; green = b0; blue = b0;
        end else if (s1.miss) begin
          red = '0; green = '0; blue = '0; alpha = '0;
        end else begin
          red = pal_data[23:16]; green = pal_data[15:8]; blue = pal_data[7:0];
        end
      end
      FMT_16: begin
        red   = {p[14:10], 3'b000};
        green = {p[9:5], 3'b000};
        blue  = {p[4:0], 3'b000};
      end
      FMT_24: begin
        red = b2; green = b1; blue = b0;
      end
      default: begin
        red = b2; green = b1; blue = b0; alpha = s1.last;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {s1.count, alpha, blue, green, red};
    end
  end

endmodule

// ----- hw/rtl/tga_rle_checker.sv -----
// port-level checks of the tga run-length pixel decoder, bound to the top level
module tga_rle_assertions (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // a stalled result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // every result covers at least one pixel
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:32] != 8'd0)
    else $error("zero repeat count");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // with the output register free the input side is never blocked
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind tga_rle_pixel_decoder_unit tga_rle_assertions u_checker (.*);

// ----- bench/tga_rle_checker.sv -----
`timescale 1ns / 1ps
// checker for the tga run-length pixel decoder: mirrors the decoder and compares every colour
module tga_rle_checker import tga_rle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          fails,
  output int          pending
);

  // same layout as m_tdata: red in the lowest byte, repeat count on top
  typedef struct packed {
    logic [7:0] count;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } colour_t;

  logic [23:0] palette [256];
  fmt_t        fmt;
  logic        rle_on;
  logic [8:0]  pal_len;
  logic [7:0]  left;
  logic        is_run;
  logic [23:0] gathered;
  logic [1:0]  pos;

  colour_t     colour_q [$];
  int          err_cnt;
  colour_t     px, want, got;

  function automatic bit decode_stream_byte(input logic [7:0] d, output colour_t c);
    int          size;
    logic [15:0] p;
    logic [23:0] entry;
    c = '0;
    if (rle_on && left == 8'd0) begin
      is_run   = d[7];
      left     = {1'b0, d[6:0]} + 8'd1;
      gathered = '0;
      pos      = '0;
      return 1'b0;
    end
    size = int'(fmt) + 1;
    if (int'(pos) + 1 < size) begin
      gathered = gathered | (24'(d) << (8 * pos));
      pos      = pos + 2'd1;
      return 1'b0;
    end
    if (pos < 2'd3)
      gathered = gathered | (24'(d) << (8 * pos));
    c.alpha = ALPHA_OPAQUE;
    case (fmt)
      FMT_8: begin
        if (pal_len != 9'd0) begin
          if ({1'b0, gathered[7:0]} < pal_len) begin
            entry   = palette[gathered[7:0]];
            c.red   = entry[23:16];
            c.green = entry[15:8];
            c.blue  = entry[7:0];
          end else begin
            c.alpha = 8'h00;
          end
        end else begin
          c.red   = gathered[7:0];
          c.green = gathered[7:0];
          c.blue  = gathered[7:0];
        end
      end
      FMT_16: begin
        p       = gathered[15:0];
        c.red   = {p[14:10], 3'b000};
        c.green = {p[9:5], 3'b000};
        c.blue  = {p[4:0], 3'b000};
      end
      FMT_24: begin
        c.red   = gathered[23:16];
        c.green = gathered[15:8];
        c.blue  = gathered[7:0];
      end
      default: begin
        c.red   = gathered[23:16];
        c.green = gathered[15:8];
        c.blue  = gathered[7:0];
        c.alpha = d;
      end
    endcase
    gathered = '0;
    pos      = '0;
    c.count  = 8'd1;
    if (rle_on) begin
      if (is_run) begin
        c.count = left;
        left    = 8'd0;
      end else begin
        left = left - 8'd1;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fmt      = FMT_24;
      rle_on   = 1'b0;
      pal_len  = '0;
      left     = '0;
      is_run   = 1'b0;
      gathered = '0;
      pos      = '0;
      err_cnt  = 0;
      colour_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PIXEL_FORMAT:   fmt = fmt_t'(cfg_data[1:0]);
          CFG_RLE_ENABLED:    rle_on = cfg_data[0];
          CFG_PALETTE_LENGTH: pal_len = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == FUNC_PALETTE)
          palette[s_tdata[7:0]] = s_tdata[31:8];
        else if (decode_stream_byte(s_tdata[39:32], px))
          colour_q.push_back(px);
      end
      if (m_tvalid && m_tready) begin
        got = colour_t'(m_tdata);
        if (colour_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected colour r=%0d g=%0d b=%0d a=%0d n=%0d",
                     got.red, got.green, got.blue, got.alpha, got.count);
        end else begin
          want = colour_q.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
              got.alpha !== want.alpha || got.count !== want.count) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("colour mismatch: expected r=%0d g=%0d b=%0d a=%0d n=%0d, %s",
                       want.red, want.green, want.blue, want.alpha, want.count,
                       $sformatf("got r=%0d g=%0d b=%0d a=%0d n=%0d",
                                 got.red, got.green, got.blue, got.alpha, got.count));
          end
        end
      end
    end
    fails   <= err_cnt;
    pending <= colour_q.size();
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// top of the tga run-length pixel decoder bench: clock, reset, stimulus and verdict
module testbench;
  import tga_rle_pkg::*;

  // longest stretch without any handshake before the run is declared hung
  localparam int STALL_LIMIT  = 3000;
  // one long receiver hold-off so the pipeline fills and s_tready drops
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 850;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // palette_index[7:0], palette_color[31:8], data_byte[39:32]
  logic        s_tuser;   // func: 0 palette write, 1 pixel data byte
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // red[7:0], green[15:8], blue[23:16], alpha[31:24], repeat_count[39:32]
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  int          fails;
  int          pending;

  // idling percentages for each side, changed between phases
  int          tx_idle;
  int          rx_idle;
  bit          hold_req;
  bit          hold_taken;
  int          hold_left;
  int          items_sent;
  int          quiet_cycles;

  // what the stimulus knows of the block, so that no unwritten palette entry is read
  bit          wr_mask [256];
  fmt_t        cur_fmt;
  bit          cur_rle;
  int          cur_len;

  tga_rle_pixel_decoder_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tga_rle_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver: random back-pressure, plus one long hold-off counted here,
  // started once the sender is offering items
  initial begin
    m_tready   = 1'b0;
    hold_taken = 1'b0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken && s_tvalid) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle);
      end
    end
  end

  // watchdog: any accepted item on either side restarts the count
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // offer one item at a falling edge, after random idling, and hold it until accepted
  task automatic drive(input logic func, input logic [39:0] word);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // palette write; the unused data byte carries noise
  task automatic send_pal(input logic [7:0] idx, input logic [23:0] colour);
    wr_mask[idx] = 1'b1;
    drive(FUNC_PALETTE, {8'($urandom), colour, idx});
  endtask

  // stream byte; the unused palette fields carry noise
  task automatic send_byte(input logic [7:0] d);
    drive(FUNC_PIXEL, {d, 32'($urandom)});
  endtask

  // drop valid, let every colour arrive, then allow for the pipeline latency
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // cfg_we stays high across back-to-back writes, the caller lowers it
  task automatic write_reg(input cfg_idx_t idx, input logic [8:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_mode(input fmt_t f, input bit rle_on, input int len);
    wait_idle();
    write_reg(CFG_PIXEL_FORMAT, 9'(f));
    write_reg(CFG_RLE_ENABLED, 9'(rle_on));
    write_reg(CFG_PALETTE_LENGTH, 9'(len));
    @(negedge clk);
    cfg_we  <= 1'b0;
    cur_fmt = f;
    cur_rle = rle_on;
    cur_len = len;
  endtask

  // byte values lean towards the extremes now and then
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // one whole pixel in the current format
  task automatic send_pixel();
    logic [7:0] idx;
    if (cur_fmt == FMT_8 && cur_len != 0) begin
      idx = rand_byte();
      // a hit on a never-written entry gets that entry loaded first
      if (idx < cur_len && !wr_mask[idx])
        send_pal(idx, 24'($urandom));
      send_byte(idx);
    end else begin
      repeat (int'(cur_fmt) + 1) send_byte(rand_byte());
    end
  endtask

  // one packet in run-length mode, one pixel in plain mode, sometimes a stray palette write
  task automatic send_packet();
    int   n;
    logic run;
    if ($urandom_range(0, 9) == 0)
      send_pal(8'($urandom), 24'($urandom));
    if (!cur_rle) begin
      send_pixel();
      return;
    end
    run = $urandom_range(0, 1);
    // mostly short packets, the odd one up to the full 128
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
    send_byte({run, 7'(n - 1)});
    if (run)
      send_pixel();
    else
      repeat (n) send_pixel();
  endtask

  // random settings, each kept for a batch of whole packets
  task automatic run_phase(input int items);
    int stop;
    int len;
    stop = items_sent + items;
    while (items_sent < stop) begin
      case ($urandom_range(0, 3))
        0:       len = 0;
        1:       len = 256;
        2:       len = 1;
        default: len = $urandom_range(2, 255);
      endcase
      set_mode(fmt_t'($urandom_range(0, 3)), $urandom_range(0, 1), len);
      repeat ($urandom_range(8, 30)) begin
        if (items_sent < stop)
          send_packet();
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tuser    = 1'b0;
    s_tdata    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    hold_req   = 1'b0;
    tx_idle    = 11;
    rx_idle    = 48;
    items_sent = 0;
    cur_fmt    = FMT_24;
    cur_rle    = 1'b0;
    cur_len    = 0;
    foreach (wr_mask[i]) wr_mask[i] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: 24-bit plain pixels
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);

    // 32-bit with alpha from the fourth byte
    set_mode(FMT_32, 1'b0, 0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h01);

    // 5-5-5 with all colour bits set
    set_mode(FMT_16, 1'b0, 0);
    send_byte(8'hFF);
    send_byte(8'h7F);

    // 8-bit gray
    set_mode(FMT_8, 1'b0, 0);
    send_byte(8'hFF);

    // palette lookups: full length, then a single entry so index 1 misses
    send_pal(8'hFF, 24'h123456);
    send_pal(8'h00, 24'hFFFFFF);
    set_mode(FMT_8, 1'b0, 256);
    send_byte(8'hFF);
    set_mode(FMT_8, 1'b0, 1);
    send_byte(8'h00);
    send_byte(8'h01);

    // run-length packets: shortest run, longest run, two raw pixels
    set_mode(FMT_8, 1'b1, 0);
    send_byte(8'h80);
    send_byte(8'h5A);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h01);
    send_byte(8'h22);
    send_byte(8'h33);

    // format changed with bytes gathered: the pixel completes on the next byte
    set_mode(FMT_32, 1'b0, 0);
    send_byte(8'hC3);
    send_byte(8'h3C);
    send_byte(8'h99);
    set_mode(FMT_8, 1'b0, 0);
    send_byte(8'h42);
    set_mode(FMT_32, 1'b0, 0);
    send_byte(8'h1F);
    send_byte(8'h7C);
    set_mode(FMT_16, 1'b0, 0);
    send_byte(8'h55);

    // random part in three idling phases
    run_phase(RANDOM_ITEMS / 3);
    tx_idle = 48;
    rx_idle = 11;
    run_phase(RANDOM_ITEMS / 3);
    tx_idle  = 0;
    rx_idle  = 0;
    hold_req = 1'b1;
    run_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    // drain and allow for the pipeline latency
    wait_idle();
    repeat (6) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tga_rle_pkg.sv
hw/rtl/tga_rle_palette.sv
hw/rtl/tga_rle_parse.sv
hw/rtl/tga_rle_color.sv
hw/rtl/tga_rle_pixel_decoder_unit.sv
hw/rtl/tga_rle_checker.sv
bench/tga_rle_checker.sv
bench/testbench.sv
